// ===== rtl/fnam_pkg.sv =====
// Shared types, constants and helpers for the NOR flash array model.
package fnam_pkg;

    localparam int FLASH_BYTES_DEF = 65536;
    localparam int MAX_PROG_DEF    = 256;
    localparam int QUEUE_DEPTH     = 4;
    localparam int IDX_W           = 12;
    localparam int LEN_W           = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [7:0] ERASED = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ,
        OP_ERASE,
        OP_HEADER,
        OP_DATA
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_NEEDS_ERASE,
        ST_POWER_LOSS
    } t_status;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_ERASE,
        CMD_STAGE,
        CMD_COMMIT,
        CMD_REPORT
    } t_cmd_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROG_UNIT,
        CFG_ERASE_BLOCK,
        CFG_FAIL_EN,
        CFG_FAIL_AFTER
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_ERASE,
        S_CHK_RD,
        S_CHK_CMP,
        S_WR_RD,
        S_WR_WR
    } t_back_state;

    // One classified command handed from the front to the back
    typedef struct packed {
        t_cmd_kind         kind;
        logic [15:0]       addr;
        logic [LEN_W-1:0]  len;
        logic [7:0]        data;
        logic [IDX_W-1:0]  idx;
        t_status           status;
    } t_cmd;

    // True when v is a multiple of 2**lg (lg beyond the width means v must be zero)
    function automatic logic is_aligned(logic [LEN_W-1:0] v, logic [4:0] lg);
        logic [LEN_W-1:0] mask;
        for (int b = 0; b < LEN_W; b++) begin
            mask[b] = (5'(b) < lg);
        end
        return (v & mask) == '0;
    endfunction

endpackage

// ===== rtl/fnam_queue.sv =====
// Small command FIFO between the front and the back.
module fnam_queue #(
    parameter int DEPTH = fnam_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fnam_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output fnam_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import fnam_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/fnam_front.sv =====
// Front end: accepts items, checks arguments, tracks the open program, issues commands.
module fnam_front #(
    parameter int FLASH_BYTES       = fnam_pkg::FLASH_BYTES_DEF,
    parameter int MAX_PROGRAM_BYTES = fnam_pkg::MAX_PROG_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_operation,
    input  logic [15:0]                i_address,
    input  logic [fnam_pkg::LEN_W-1:0] i_length,
    input  logic [7:0]                 i_data_byte,
    input  logic [3:0]                 i_prog_unit_log2,
    input  logic [4:0]                 i_erase_block_log2,
    input  logic                       i_q_full,
    input  logic                       i_init_done,
    output logic                       o_push,
    output fnam_pkg::t_cmd             o_cmd
);
    import fnam_pkg::*;

    localparam int CW = $clog2(MAX_PROGRAM_BYTES + 1);

    logic          r_open, n_open;
    logic [15:0]   r_base, n_base;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_rcvd, n_rcvd;

    logic          accept;
    logic          emit;
    logic [17:0]   end_addr;
    logic          in_array;
    logic          read_ok;
    logic          erase_ok;
    logic          header_ok;
    logic [CW:0]   rcvd_inc;
    t_op           op;

    assign op         = t_op'(i_operation);
    assign o_in_stall = i_q_full || !i_init_done;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = accept && emit;

    // argument checks
    assign end_addr  = {2'b00, i_address} + {1'b0, i_length};
    assign in_array  = 32'(end_addr) <= 32'(FLASH_BYTES);
    assign read_ok   = 32'(i_address) < 32'(FLASH_BYTES);
    assign erase_ok  = in_array && is_aligned({1'b0, i_address}, i_erase_block_log2)
                       && is_aligned(i_length, i_erase_block_log2);
    assign header_ok = in_array && is_aligned({1'b0, i_address}, {1'b0, i_prog_unit_log2})
                       && is_aligned(i_length, {1'b0, i_prog_unit_log2})
                       && (32'(i_length) <= 32'(MAX_PROGRAM_BYTES));
    assign rcvd_inc  = {1'b0, r_rcvd} + 1'b1;

    // classify the item and update the program state
    always_comb begin
        n_open  = r_open;
        n_base  = r_base;
        n_total = r_total;
        n_rcvd  = r_rcvd;
        emit    = 1'b1;
        o_cmd.kind   = CMD_REPORT;
        o_cmd.addr   = i_address;
        o_cmd.len    = i_length;
        o_cmd.data   = i_data_byte;
        o_cmd.idx    = IDX_W'(r_rcvd);
        o_cmd.status = ST_INVALID;
        case (op)
            OP_READ: begin
                if (read_ok) begin
                    o_cmd.kind = CMD_READ;
                end
            end
            OP_ERASE: begin
                if (erase_ok) begin
                    if (i_length == '0) begin
                        o_cmd.status = ST_OK;
                    end else begin
                        o_cmd.kind = CMD_ERASE;
                    end
                end
            end
            OP_HEADER: begin
                n_open = 1'b0;
                n_rcvd = '0;
                if (header_ok) begin
                    if (i_length == '0) begin
                        o_cmd.status = ST_OK;
                    end else begin
                        emit    = 1'b0;
                        n_open  = 1'b1;
                        n_base  = i_address;
                        n_total = CW'(i_length);
                    end
                end
            end
            OP_DATA: begin
                if (r_open && (r_rcvd < r_total)) begin
                    if (rcvd_inc < {1'b0, r_total}) begin
                        o_cmd.kind = CMD_STAGE;
                        n_rcvd     = rcvd_inc[CW-1:0];
                    end else begin
                        // last byte: hand the whole run over for commit
                        o_cmd.kind = CMD_COMMIT;
                        o_cmd.addr = r_base;
                        o_cmd.len  = LEN_W'(r_total);
                        n_open     = 1'b0;
                        n_rcvd     = '0;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_base  <= '0;
            r_total <= '0;
            r_rcvd  <= '0;
        end else if (accept) begin
            r_open  <= n_open;
            r_base  <= n_base;
            r_total <= n_total;
            r_rcvd  <= n_rcvd;
        end
    end

endmodule

// ===== rtl/fnam_back.sv =====
// Back end: owns the flash array and stage buffer, runs reads, erases and commits.
module fnam_back #(
    parameter int FLASH_BYTES       = fnam_pkg::FLASH_BYTES_DEF,
    parameter int MAX_PROGRAM_BYTES = fnam_pkg::MAX_PROG_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  fnam_pkg::t_cmd i_cmd,
    output logic           o_pop,
    input  logic           i_fail_enable,
    input  logic [31:0]    i_fail_after,
    input  logic           i_count_clear,
    output logic           o_init_done,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_status,
    output logic [7:0]     o_read_data
);
    import fnam_pkg::*;

    localparam int AW = $clog2(FLASH_BYTES);
    localparam int SW = (MAX_PROGRAM_BYTES > 1) ? $clog2(MAX_PROGRAM_BYTES) : 1;

    logic [7:0] r_flash_mem [FLASH_BYTES];
    logic [7:0] r_stage_mem [MAX_PROGRAM_BYTES];
    logic [7:0] r_flash_q;
    logic [7:0] r_stage_q;

    t_back_state      r_state, n_state;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_base, n_base;
    logic [SW-1:0]    r_sidx, n_sidx;
    logic [LEN_W-1:0] r_left, n_left;
    logic [LEN_W-1:0] r_total, n_total;
    logic [31:0]      r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [7:0]       r_out_data, n_out_data;

    logic             fl_we;
    logic [7:0]       fl_wdata;
    logic             st_we;
    logic [SW-1:0]    st_waddr;
    logic [31:0]      cmd_addr32;
    logic             mismatch;
    logic             fail_now;
    logic             last_byte;
    logic             clear_last;

    assign o_pop       = (r_state == S_IDLE) && !i_q_empty && !r_out_valid;
    assign o_init_done = (r_state != S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_read_data = r_out_data;

    assign cmd_addr32 = 32'(i_cmd.addr);
    assign mismatch   = (r_flash_q & r_stage_q) != r_stage_q;
    assign fail_now   = i_fail_enable && (r_count >= i_fail_after);
    assign last_byte  = (r_left == LEN_W'(1));
    assign clear_last = (r_ptr == AW'(FLASH_BYTES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.kind)
                        CMD_READ:   n_state = S_RD1;
                        CMD_ERASE:  n_state = S_ERASE;
                        CMD_COMMIT: n_state = S_CHK_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RD1:     n_state = S_RD2;
            S_RD2:     n_state = S_IDLE;
            S_ERASE: begin
                if (last_byte) n_state = S_IDLE;
            end
            S_CHK_RD:  n_state = S_CHK_CMP;
            S_CHK_CMP: begin
                if (mismatch) begin
                    n_state = S_IDLE;
                end else if (last_byte) begin
                    n_state = S_WR_RD;
                end else begin
                    n_state = S_CHK_RD;
                end
            end
            S_WR_RD: begin
                n_state = fail_now ? S_IDLE : S_WR_WR;
            end
            S_WR_WR: begin
                n_state = last_byte ? S_IDLE : S_WR_RD;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and result register
    always_comb begin
        n_ptr        = r_ptr;
        n_base       = r_base;
        n_sidx       = r_sidx;
        n_left       = r_left;
        n_total      = r_total;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        fl_we        = 1'b0;
        fl_wdata     = ERASED;
        st_we        = 1'b0;
        st_waddr     = i_cmd.idx[SW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                fl_we = 1'b1;
                n_ptr = r_ptr + 1'b1;
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_ptr   = cmd_addr32[AW-1:0];
                    n_base  = cmd_addr32[AW-1:0];
                    n_left  = i_cmd.len;
                    n_total = i_cmd.len;
                    n_sidx  = '0;
                    case (i_cmd.kind)
                        CMD_STAGE, CMD_COMMIT: begin
                            st_we = 1'b1;
                        end
                        CMD_REPORT: begin
                            n_out_valid  = 1'b1;
                            n_out_status = i_cmd.status;
                            n_out_data   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD2: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_data   = r_flash_q;
            end
            S_ERASE: begin
                fl_we  = 1'b1;
                n_ptr  = r_ptr + 1'b1;
                n_left = r_left - 1'b1;
                if (last_byte) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_data   = '0;
                end
            end
            S_CHK_CMP: begin
                if (mismatch) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_NEEDS_ERASE;
                    n_out_data   = '0;
                end else if (last_byte) begin
                    // check passed: rewind for the write pass
                    n_ptr  = r_base;
                    n_sidx = '0;
                    n_left = r_total;
                end else begin
                    n_ptr  = r_ptr + 1'b1;
                    n_sidx = r_sidx + 1'b1;
                    n_left = r_left - 1'b1;
                end
            end
            S_WR_RD: begin
                if (fail_now) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_POWER_LOSS;
                    n_out_data   = '0;
                end
            end
            S_WR_WR: begin
                fl_we    = 1'b1;
                fl_wdata = r_flash_q & r_stage_q;
                n_count  = r_count + 1'b1;
                n_ptr    = r_ptr + 1'b1;
                n_sidx   = r_sidx + 1'b1;
                n_left   = r_left - 1'b1;
                if (last_byte) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_data   = '0;
                end
            end
            default: begin
            end
        endcase

        if (i_count_clear) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base       <= n_base;
        r_sidx       <= n_sidx;
        r_left       <= n_left;
        r_total      <= n_total;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    // flash array: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            r_flash_mem[r_ptr] <= fl_wdata;
        end
        r_flash_q <= r_flash_mem[r_ptr];
    end

    // stage buffer
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stage_mem[st_waddr] <= i_cmd.data;
        end
        r_stage_q <= r_stage_mem[r_sidx];
    end

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result present during clearing pass");
    a_walk_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERASE || r_state == S_WR_WR || r_state == S_CHK_CMP) |-> (r_left != '0))
        else $error("byte walk with zero bytes left");
    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_WR) |-> ($past(r_state) == S_WR_RD))
        else $error("program write without its read cycle");
`endif

endmodule

// ===== rtl/nor_flash_array_model.sv =====
// Top level of the NOR flash array model: config registers, front, queue and back.
//
// After reset the array (FLASH_BYTES bytes, 65536 by default) is swept to 0xFF
// one byte per cycle, during which no item is taken; config writes are taken at
// any time. Items then enter a four-deep command queue. The array is a single
// memory with one write and one registered read per cycle, and that port sets
// the timing: a read passes S_RD1 and S_RD2 before its registered result, an
// erase walks its bytes, a commit checks every byte and then writes every byte,
// and data bytes that are only staged go straight into the stage buffer.
module nor_flash_array_model #(
    parameter int FLASH_BYTES       = fnam_pkg::FLASH_BYTES_DEF,
    parameter int MAX_PROGRAM_BYTES = fnam_pkg::MAX_PROG_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [15:0]                     i_address,
    input  logic [fnam_pkg::LEN_W-1:0]      i_length,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [7:0]                      o_read_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fnam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fnam_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fnam_pkg::*;

    logic [3:0]  r_prog_unit_log2;
    logic [4:0]  r_erase_block_log2;
    logic        r_fail_enable;
    logic [31:0] r_fail_after;
    logic        cfg_write;
    logic        count_clear;

    logic        q_push, q_pop, q_full, q_empty, init_done;
    t_cmd        front_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign count_clear = cfg_write && ((t_cfg_idx'(i_cfg_index) == CFG_FAIL_EN)
                         || (t_cfg_idx'(i_cfg_index) == CFG_FAIL_AFTER));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_unit_log2   <= 4'd0;
            r_erase_block_log2 <= 5'd12;
            r_fail_enable      <= 1'b0;
            r_fail_after       <= '0;
        end else if (cfg_write) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROG_UNIT:   r_prog_unit_log2   <= i_cfg_data[3:0];
                CFG_ERASE_BLOCK: r_erase_block_log2 <= i_cfg_data[4:0];
                CFG_FAIL_EN:     r_fail_enable      <= i_cfg_data[0];
                CFG_FAIL_AFTER:  r_fail_after       <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    fnam_front #(
        .FLASH_BYTES       (FLASH_BYTES),
        .MAX_PROGRAM_BYTES (MAX_PROGRAM_BYTES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_address          (i_address),
        .i_length           (i_length),
        .i_data_byte        (i_data_byte),
        .i_prog_unit_log2   (r_prog_unit_log2),
        .i_erase_block_log2 (r_erase_block_log2),
        .i_q_full           (q_full),
        .i_init_done        (init_done),
        .o_push             (q_push),
        .o_cmd              (front_cmd)
    );

    fnam_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    fnam_back #(
        .FLASH_BYTES       (FLASH_BYTES),
        .MAX_PROGRAM_BYTES (MAX_PROGRAM_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (head_cmd),
        .o_pop         (q_pop),
        .i_fail_enable (r_fail_enable),
        .i_fail_after  (r_fail_after),
        .i_count_clear (count_clear),
        .o_init_done   (init_done),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_data   (o_read_data)
    );

endmodule
